/* rtl/rgb_to_yuv420_pixel_stream_macros.svh */
// Assertion macros shared by the pixel stream checker.
`ifndef RGB_TO_YUV420_PIXEL_STREAM_MACROS_SVH
`define RGB_TO_YUV420_PIXEL_STREAM_MACROS_SVH

// check a property on every clock edge outside reset
`define RYUV_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check a property on every clock edge, reset included
`define RYUV_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/ryuv_pkg.sv */
// Shared constants and types of the RGB to YUV 4:2:0 pixel stream converter.
package ryuv_pkg;

   localparam int MAX_DIMENSION = 4096;
   localparam int COUNT_WIDTH   = $clog2(MAX_DIMENSION);
   localparam int DIM_WIDTH     = COUNT_WIDTH + 1;
   localparam int CFG_WIDTH     = 13;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int COMP_WIDTH    = 8;

   localparam logic [CFG_WIDTH-1:0] FRAME_WIDTH_RESET  = CFG_WIDTH'(1280);
   localparam logic [CFG_WIDTH-1:0] FRAME_HEIGHT_RESET = CFG_WIDTH'(720);

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [DIM_WIDTH-1:0] width;
      logic [DIM_WIDTH-1:0] height;
   } frame_cfg_type;

   typedef struct packed {
      logic [COMP_WIDTH-1:0] blue;
      logic [COMP_WIDTH-1:0] green;
      logic [COMP_WIDTH-1:0] red;
   } rgb_type;

   typedef struct packed {
      logic [COMP_WIDTH-1:0] chroma_red;
      logic [COMP_WIDTH-1:0] chroma_blue;
      logic [COMP_WIDTH-1:0] luma;
   } yuv_type;

endpackage

/* rtl/ryuv_csr.sv */
// Configuration registers with effective frame width and height.
module ryuv_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ryuv_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [ryuv_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [ryuv_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready,
   output ryuv_pkg::frame_cfg_type              frame_cfg
);

   logic [ryuv_pkg::CFG_WIDTH-1:0] frame_width_ff;
   logic [ryuv_pkg::CFG_WIDTH-1:0] frame_width_in;
   logic [ryuv_pkg::CFG_WIDTH-1:0] frame_height_ff;
   logic [ryuv_pkg::CFG_WIDTH-1:0] frame_height_in;
   logic [ryuv_pkg::CFG_WIDTH-1:0] width_even;
   ryuv_pkg::reg_index_type        reg_index;
   logic                           write_strobe;

   assign csr_pready   = 1'b1;
   assign write_strobe = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index    = ryuv_pkg::reg_index_type'(csr_paddr[2]);

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (write_strobe) begin
         case (reg_index)
            ryuv_pkg::REG_FRAME_WIDTH:  frame_width_in  = csr_pwdata[ryuv_pkg::CFG_WIDTH-1:0];
            ryuv_pkg::REG_FRAME_HEIGHT: frame_height_in = csr_pwdata[ryuv_pkg::CFG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= ryuv_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= ryuv_pkg::FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   always_comb begin
      case (reg_index)
         ryuv_pkg::REG_FRAME_WIDTH:
            csr_prdata = ryuv_pkg::CSR_DATA_WIDTH'(frame_width_ff);
         ryuv_pkg::REG_FRAME_HEIGHT:
            csr_prdata = ryuv_pkg::CSR_DATA_WIDTH'(frame_height_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   assign width_even = {frame_width_ff[ryuv_pkg::CFG_WIDTH-1:1], 1'b0};

   always_comb begin
      if (width_even == '0) begin
         frame_cfg.width = ryuv_pkg::DIM_WIDTH'(2);
      end else if (int'(width_even) > ryuv_pkg::MAX_DIMENSION) begin
         frame_cfg.width = ryuv_pkg::DIM_WIDTH'(ryuv_pkg::MAX_DIMENSION);
      end else begin
         frame_cfg.width = ryuv_pkg::DIM_WIDTH'(width_even);
      end
      if (frame_height_ff == '0) begin
         frame_cfg.height = ryuv_pkg::DIM_WIDTH'(1);
      end else if (int'(frame_height_ff) > ryuv_pkg::MAX_DIMENSION) begin
         frame_cfg.height = ryuv_pkg::DIM_WIDTH'(ryuv_pkg::MAX_DIMENSION);
      end else begin
         frame_cfg.height = ryuv_pkg::DIM_WIDTH'(frame_height_ff);
      end
   end

endmodule

/* rtl/ryuv_convert.sv */
// BT.601 integer color conversion of one pixel.
module ryuv_convert (
   input  ryuv_pkg::rgb_type pixel,
   input  logic              chroma_valid,
   output ryuv_pkg::yuv_type yuv
);

   logic [16:0] red_ext;
   logic [16:0] green_ext;
   logic [16:0] blue_ext;
   logic [16:0] luma_sum;
   logic [16:0] blue_sum;
   logic [16:0] red_sum;

   assign red_ext   = 17'(pixel.red);
   assign green_ext = 17'(pixel.green);
   assign blue_ext  = 17'(pixel.blue);

   // chroma sums carry a bias of 128*256 and never go negative
   assign luma_sum = 17'd66 * red_ext + 17'd129 * green_ext + 17'd25 * blue_ext;
   assign blue_sum = 17'd32768 + 17'd112 * blue_ext - 17'd38 * red_ext - 17'd74 * green_ext;
   assign red_sum  = 17'd32768 + 17'd112 * red_ext - 17'd94 * green_ext - 17'd18 * blue_ext;

   assign yuv.luma        = luma_sum[15:8] + 8'd16;
   assign yuv.chroma_blue = chroma_valid ? blue_sum[15:8] : '0;
   assign yuv.chroma_red  = chroma_valid ? red_sum[15:8] : '0;

endmodule

/* rtl/rgb_to_yuv420_pixel_stream.sv */
// Top level of the RGB to YUV 4:2:0 pixel stream converter.
//
//   channel  direction  contents
//   req      in         tdata: red, green, blue
//   rsp      out        tdata: luma, chroma_blue, chroma_red; tuser: chroma_valid;
//                       tlast: end_of_frame
//   csr      in/out     APB registers frame_width (0x0), frame_height (0x4)
//
// One pixel per cycle unless stalled; each passes the input, then the result register.
// Column and line counters advance when a pixel enters the input register.
// Reset clears the counters and the stage valid flags and loads width 1280, height 720.
// A stalled result holds; the input register keeps accepting while it is empty.
module rgb_to_yuv420_pixel_stream (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,   // red, green, blue
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [23:0]                         rsp_tdata,   // luma, chroma_blue, chroma_red
   output logic                                rsp_tuser,   // chroma_valid
   output logic                                rsp_tlast,   // end_of_frame
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ryuv_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [ryuv_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [ryuv_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);

   ryuv_pkg::frame_cfg_type          frame_cfg;
   logic [ryuv_pkg::COUNT_WIDTH-1:0] column_count_ff;
   logic [ryuv_pkg::COUNT_WIDTH-1:0] column_count_in;
   logic [ryuv_pkg::COUNT_WIDTH-1:0] line_count_ff;
   logic [ryuv_pkg::COUNT_WIDTH-1:0] line_count_in;
   logic                             last_column;
   logic                             last_line;
   logic                             accept;
   logic                             stage_ready;
   logic                             out_ready;
   logic                             stage_valid_ff;
   logic                             stage_valid_in;
   ryuv_pkg::rgb_type                stage_pixel_ff;
   logic                             stage_chroma_ff;
   logic                             stage_last_ff;
   ryuv_pkg::yuv_type                stage_yuv;
   logic                             out_valid_ff;
   logic                             out_valid_in;
   ryuv_pkg::yuv_type                out_yuv_ff;
   logic                             out_chroma_ff;
   logic                             out_last_ff;

   ryuv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .frame_cfg   (frame_cfg)
   );

   assign out_ready   = !out_valid_ff || rsp_tready;
   assign stage_ready = !stage_valid_ff || out_ready;
   assign req_tready  = stage_ready;
   assign accept      = req_tvalid && req_tready;

   assign last_column = (ryuv_pkg::DIM_WIDTH'(column_count_ff) + ryuv_pkg::DIM_WIDTH'(1))
                        >= frame_cfg.width;
   assign last_line   = (ryuv_pkg::DIM_WIDTH'(line_count_ff) + ryuv_pkg::DIM_WIDTH'(1))
                        >= frame_cfg.height;

   always_comb begin
      column_count_in = column_count_ff;
      line_count_in   = line_count_ff;
      if (accept) begin
         if (last_column) begin
            column_count_in = '0;
            line_count_in   = last_line ? '0 : line_count_ff + ryuv_pkg::COUNT_WIDTH'(1);
         end else begin
            column_count_in = column_count_ff + ryuv_pkg::COUNT_WIDTH'(1);
         end
      end
   end

   assign stage_valid_in = stage_ready ? req_tvalid : stage_valid_ff;
   assign out_valid_in   = out_ready ? stage_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         line_count_ff   <= '0;
         stage_valid_ff  <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         column_count_ff <= column_count_in;
         line_count_ff   <= line_count_in;
         stage_valid_ff  <= stage_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_pixel_ff  <= req_tdata;
         stage_chroma_ff <= !column_count_ff[0] && !line_count_ff[0];
         stage_last_ff   <= last_column && last_line;
      end
      if (out_ready && stage_valid_ff) begin
         out_yuv_ff    <= stage_yuv;
         out_chroma_ff <= stage_chroma_ff;
         out_last_ff   <= stage_last_ff;
      end
   end

   ryuv_convert u_convert (
      .pixel        (stage_pixel_ff),
      .chroma_valid (stage_chroma_ff),
      .yuv          (stage_yuv)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_yuv_ff;
   assign rsp_tuser  = out_chroma_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

/* rtl/ryuv_checker.sv */
// Port-level assertions for the pixel stream converter, bound to the top level.
`include "rgb_to_yuv420_pixel_stream_macros.svh"

module ryuv_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        csr_pready
);

   `RYUV_ASSERT_ALWAYS(a_reset_clears_output, reset |=> !rsp_tvalid,
                       "output valid after reset")
   `RYUV_ASSERT(a_stall_holds,
                rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata),
                "stalled transaction dropped or changed")
   `RYUV_ASSERT(a_chroma_zero, rsp_tvalid && !rsp_tuser |-> rsp_tdata[23:8] == 16'd0,
                "chroma not zero without chroma_valid")
   `RYUV_ASSERT(a_luma_range,
                rsp_tvalid |-> rsp_tdata[7:0] >= 8'd16 && rsp_tdata[7:0] <= 8'd235,
                "luma out of range")
   `RYUV_ASSERT_ALWAYS(a_pready_high, csr_pready, "csr_pready low")

endmodule

bind rgb_to_yuv420_pixel_stream ryuv_checker u_ryuv_checker (.*);
